### rtl/hml_pkg.sv
`timescale 1ns / 1ps

package hml_pkg;

    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 20;
    localparam int LVL_BITS   = $clog2(LEVELS);
    localparam int PROD_BITS  = 2 * COUNT_BITS;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_CNT_SRC = 3'd1;
    localparam logic [2:0] OP_CNT_REF = 3'd2;
    localparam logic [2:0] OP_BUILD = 3'd3;
    localparam logic [2:0] OP_MAP = 3'd4;

    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_BUILT = 1'b1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] pixel;
    } in_beat_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] mapped_pixel;
    } out_beat_t;

    // Requests from the sequencer to the shared multiply/compare unit
    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] c1;
        logic [COUNT_BITS-1:0] c2;
        logic [COUNT_BITS-1:0] t1;
        logic [COUNT_BITS-1:0] t2;
    } cmp_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] diff;
    } cmp_rsp_t;

endpackage

### rtl/hml_diff_unit.sv
`timescale 1ns / 1ps

// Shared unit: |c1*t2 - c2*t1|, one multiplier used twice
module hml_diff_unit
    import hml_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmp_req_t req,
    output cmp_rsp_t rsp
);

    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] c2_reg, t1_reg;
    logic [PROD_BITS-1:0]  p1_reg, prod;
    logic [PROD_BITS-1:0]  diff_reg;
    logic                  done_reg;
    logic [COUNT_BITS-1:0] ma, mb;

    // One multiplier, operands chosen by phase
    always_comb
    begin
        ma = (phase_reg == 2'd1) ? c2_reg : req.c1;
        mb = (phase_reg == 2'd1) ? t1_reg : req.t2;
        prod = PROD_BITS'(ma) * PROD_BITS'(mb);
        phase_next = phase_reg;
        if (req.start)
            phase_next = 2'd1;
        else if (phase_reg == 2'd1)
            phase_next = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            p1_reg <= prod;
            c2_reg <= req.c2;
            t1_reg <= req.t1;
        end
        if (phase_reg == 2'd1)
            diff_reg <= (p1_reg > prod) ? (p1_reg - prod) : (prod - p1_reg);
    end

    assign rsp.done = done_reg;
    assign rsp.diff = diff_reg;

endmodule

### rtl/histogram_matching_lut_top.sv
`timescale 1ns / 1ps

// Channel | signals                    | payload
// in      | in_valid / in_ready        | in_beat_t  (opcode, pixel)
// out     | out_valid / out_ready      | out_beat_t (result_kind, mapped_pixel)
//
// Count: accept, histogram read, write back; a count into a full
//   total is dropped in the accept cycle.
// Map: accept, table read, result register.
// Clear: sweeps both histograms one bin a cycle.
// Build: reference prefix sums, then per source level LEVELS compares
//   (gather, request, wait on the diff unit) and a table write.
// After reset a clearing pass zeroes the histograms and loads identity.
// Input is not ready while a beat is in work or a result waits in the output register.
module histogram_matching_lut_top
    import hml_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CNT_R = 4'd2;
    localparam logic [3:0] S_CNT_W = 4'd3;
    localparam logic [3:0] S_MAP_R = 4'd4;
    localparam logic [3:0] S_CUM_R = 4'd5;
    localparam logic [3:0] S_CUM_W = 4'd6;
    localparam logic [3:0] S_SRC_R = 4'd7;
    localparam logic [3:0] S_CMP_R = 4'd8;
    localparam logic [3:0] S_CMP_G = 4'd9;
    localparam logic [3:0] S_CMP_W = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_TBL_W = 4'd12;
    localparam logic [3:0] S_MAP_O = 4'd13;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Memories
    logic [COUNT_BITS-1:0] src_mem [LEVELS];
    logic [COUNT_BITS-1:0] ref_mem [LEVELS];
    logic [COUNT_BITS-1:0] cum_mem [LEVELS];
    logic [7:0]            tbl_mem [LEVELS];

    logic [3:0]            state_reg;
    logic [LVL_BITS:0]     idx_reg;
    logic [LVL_BITS-1:0]   i_reg, j_reg, best_j_reg;
    logic                  side_reg;
    logic                  tbl_init_reg;
    logic [COUNT_BITS-1:0] src_tot_reg, ref_tot_reg;
    logic [COUNT_BITS-1:0] acc_reg, c1_reg;
    logic [COUNT_BITS-1:0] src_rd_reg, ref_rd_reg, cum_rd_reg;
    logic [7:0]            tbl_rd_reg;
    logic [PROD_BITS-1:0]  best_reg;
    logic                  out_valid_reg;
    out_beat_t             out_reg;
    cmp_req_t              req;
    cmp_rsp_t              rsp;
    logic [LVL_BITS-1:0]   lvl;

    assign lvl = (in_data.pixel > 8'(LEVELS - 1)) ? LVL_BITS'(LEVELS - 1)
                                                    : LVL_BITS'(in_data.pixel);

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign req.start = (state_reg == S_CMP_R);
    assign req.c1    = c1_reg;
    assign req.c2    = cum_rd_reg;
    assign req.t1    = src_tot_reg;
    assign req.t2    = ref_tot_reg;

    hml_diff_unit u_diff (
        .clk (clk),
        .rst_n (rst_n),
        .req (req),
        .rsp (rsp)
    );

    // Memory ports: registered reads at the current sweep index
    always_ff @(posedge clk)
    begin
        src_rd_reg <= src_mem[i_reg];
        ref_rd_reg <= ref_mem[i_reg];
        cum_rd_reg <= cum_mem[j_reg];
        tbl_rd_reg <= tbl_mem[i_reg];
        if (state_reg == S_INIT)
        begin
            src_mem[idx_reg[LVL_BITS-1:0]] <= '0;
            ref_mem[idx_reg[LVL_BITS-1:0]] <= '0;
        end
        else if (state_reg == S_CNT_W)
        begin
            if (side_reg)
                ref_mem[i_reg] <= ref_rd_reg + 1'b1;
            else
                src_mem[i_reg] <= src_rd_reg + 1'b1;
        end
        if (state_reg == S_CUM_W)
            cum_mem[i_reg] <= acc_reg + ref_rd_reg;
        if (state_reg == S_TBL_W)
            tbl_mem[i_reg] <= 8'(best_j_reg);
        else if (tbl_init_reg)
            tbl_mem[idx_reg[LVL_BITS-1:0]] <= 8'(idx_reg[LVL_BITS-1:0]);
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            tbl_init_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            src_tot_reg   <= '0;
            ref_tot_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            best_j_reg    <= '0;
            best_reg      <= '0;
            side_reg      <= 1'b0;
            acc_reg       <= '0;
            c1_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (LVL_BITS+1)'(LEVELS - 1))
                    begin
                        state_reg    <= S_IDLE;
                        tbl_init_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        i_reg <= lvl;
                        case (in_data.opcode)
                            OP_CLEAR:
                            begin
                                src_tot_reg <= '0;
                                ref_tot_reg <= '0;
                                idx_reg     <= '0;
                                state_reg   <= S_INIT;
                            end
                            OP_CNT_SRC:
                            begin
                                side_reg <= 1'b0;
                                if (src_tot_reg != CNT_MAX)
                                begin
                                    src_tot_reg <= src_tot_reg + 1'b1;
                                    state_reg   <= S_CNT_R;
                                end
                            end
                            OP_CNT_REF:
                            begin
                                side_reg <= 1'b1;
                                if (ref_tot_reg != CNT_MAX)
                                begin
                                    ref_tot_reg <= ref_tot_reg + 1'b1;
                                    state_reg   <= S_CNT_R;
                                end
                            end
                            OP_BUILD:
                            begin
                                i_reg     <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_CUM_R;
                            end
                            OP_MAP:
                                state_reg <= S_MAP_R;
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CNT_R:
                    state_reg <= S_CNT_W;
                S_CNT_W:
                    state_reg <= S_IDLE;
                // Table read at the new index is registered into tbl_rd_reg for S_MAP_O
                S_MAP_R:
                    state_reg <= S_MAP_O;
                S_MAP_O:
                begin
                    out_reg.result_kind  <= KIND_MAP;
                    out_reg.mapped_pixel <= tbl_rd_reg;
                    out_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                // Reference prefix sums
                S_CUM_R:
                    state_reg <= S_CUM_W;
                S_CUM_W:
                begin
                    acc_reg <= acc_reg + ref_rd_reg;
                    if (i_reg == LVL_BITS'(LEVELS - 1))
                    begin
                        i_reg     <= '0;
                        c1_reg    <= '0;
                        state_reg <= S_SRC_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_CUM_R;
                    end
                end
                // Source level i: wait for bin read
                S_SRC_R:
                begin
                    j_reg     <= '0;
                    state_reg <= S_CMP_G;
                    idx_reg   <= '0;
                end
                S_CMP_G:
                begin
                    if (idx_reg == '0)
                        c1_reg <= c1_reg + src_rd_reg;
                    idx_reg   <= '1;
                    state_reg <= S_CMP_R;
                end
                S_CMP_R:
                    state_reg <= S_CMP_W;
                S_CMP_W:
                begin
                    if (rsp.done)
                    begin
                        if (j_reg == '0 || rsp.diff < best_reg)
                        begin
                            best_reg   <= rsp.diff;
                            best_j_reg <= j_reg;
                        end
                        if (j_reg == LVL_BITS'(LEVELS - 1))
                            state_reg <= S_TBL_W;
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_CMP_G;
                        end
                    end
                end
                S_TBL_W:
                begin
                    if (i_reg == LVL_BITS'(LEVELS - 1))
                        state_reg <= S_OUT;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SRC_R;
                    end
                end
                S_OUT:
                begin
                    out_reg.result_kind  <= KIND_BUILT;
                    out_reg.mapped_pixel <= '0;
                    out_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import hml_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RAND_COUNTS = 700;
    localparam int RAND_MIXED = 720;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    // Predictor state
    logic [COUNT_BITS-1:0] src_hist [LEVELS];
    logic [COUNT_BITS-1:0] ref_hist [LEVELS];
    logic [COUNT_BITS-1:0] src_total;
    logic [COUNT_BITS-1:0] ref_total;
    logic [7:0]            match_lut [LEVELS];

    out_beat_t pending_results [$];
    int        errors;
    int        cycles;
    int        beats_sent;
    int        results_seen;
    int        builds_sent;

    // Directed stimulus rows; typed marks a hand-written expected result
    typedef struct {
        logic [2:0] opcode;
        logic [7:0] pixel;
        bit         typed;
        out_beat_t  result;
    } stim_row_t;

    localparam out_beat_t BUILT = '{result_kind: KIND_BUILT, mapped_pixel: 8'd0};

    stim_row_t directed [] = '{
        '{OP_MAP,     8'd0,   1, '{KIND_MAP, 8'd0}},     // identity after reset
        '{OP_MAP,     8'd255, 1, '{KIND_MAP, 8'd255}},
        '{OP_MAP,     8'h5a,  1, '{KIND_MAP, 8'h5a}},
        '{3'd5,       8'd1,   0, BUILT},                 // unused opcodes
        '{3'd6,       8'd2,   0, BUILT},
        '{3'd7,       8'd3,   0, BUILT},
        '{OP_BUILD,   8'd0,   1, BUILT},                 // both histograms empty
        '{OP_MAP,     8'd200, 1, '{KIND_MAP, 8'd0}},
        '{OP_MAP,     8'd255, 1, '{KIND_MAP, 8'd0}},
        '{OP_CNT_SRC, 8'd3,   0, BUILT},                 // reference side empty
        '{OP_CNT_SRC, 8'd250, 0, BUILT},
        '{OP_BUILD,   8'd0,   1, BUILT},
        '{OP_MAP,     8'd3,   0, BUILT},
        '{OP_MAP,     8'd250, 0, BUILT},
        '{OP_CLEAR,   8'd0,   0, BUILT},
        '{OP_CNT_SRC, 8'd0,   0, BUILT},                 // ties between levels
        '{OP_CNT_SRC, 8'd255, 0, BUILT},
        '{OP_CNT_REF, 8'd255, 0, BUILT},
        '{OP_CNT_REF, 8'd0,   0, BUILT},
        '{OP_CNT_REF, 8'd128, 0, BUILT},
        '{OP_BUILD,   8'd0,   1, BUILT},
        '{OP_MAP,     8'd0,   0, BUILT},
        '{OP_MAP,     8'd128, 0, BUILT},
        '{OP_MAP,     8'd255, 0, BUILT}
    };

    histogram_matching_lut_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Recompute the lookup table from both histograms
    task automatic build_match_lut();
        longint unsigned cum_ref [LEVELS];
        longint unsigned acc;
        longint unsigned c1;
        longint unsigned t1;
        longint unsigned t2;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned diff_val;
        longint unsigned best;
        int              best_j;
        acc = 0;
        c1 = 0;
        t1 = src_total;
        t2 = ref_total;
        for (int j = 0; j < LEVELS; j++)
        begin
            acc += ref_hist[j];
            cum_ref[j] = acc;
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            c1 += src_hist[i];
            lhs = c1 * t2;
            best = 0;
            best_j = 0;
            for (int j = 0; j < LEVELS; j++)
            begin
                rhs = cum_ref[j] * t1;
                diff_val = (lhs > rhs) ? lhs - rhs : rhs - lhs;
                if (j == 0 || diff_val < best)
                begin
                    best = diff_val;
                    best_j = j;
                end
            end
            match_lut[i] = best_j[7:0];
        end
    endtask

    // Apply one accepted beat; returns 1 with the expected result if there is one
    task automatic apply_beat(input in_beat_t b, output bit has_result,
                              output out_beat_t res);
        int lvl;
        lvl = (b.pixel > LEVELS - 1) ? LEVELS - 1 : b.pixel;
        has_result = 0;
        res = '0;
        case (b.opcode)
            OP_CLEAR:
            begin
                for (int k = 0; k < LEVELS; k++)
                begin
                    src_hist[k] = '0;
                    ref_hist[k] = '0;
                end
                src_total = '0;
                ref_total = '0;
            end
            OP_CNT_SRC:
            begin
                if (src_total != '1)
                begin
                    src_total++;
                    src_hist[lvl]++;
                end
            end
            OP_CNT_REF:
            begin
                if (ref_total != '1)
                begin
                    ref_total++;
                    ref_hist[lvl]++;
                end
            end
            OP_BUILD:
            begin
                build_match_lut();
                has_result = 1;
                res.result_kind = KIND_BUILT;
                builds_sent++;
            end
            OP_MAP:
            begin
                has_result = 1;
                res.result_kind = KIND_MAP;
                res.mapped_pixel = match_lut[lvl];
            end
            default:;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
        errors++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one beat, hold until accepted; called at a rising edge
    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t typed_res);
        bit        has_result;
        out_beat_t res;
        int        gap;
        in_data <= b;
        in_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        apply_beat(b, has_result, res);
        if (has_result)
            pending_results.push_back(typed ? typed_res : res);
        beats_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender pause until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic in_beat_t rand_beat(input logic [2:0] op);
        in_beat_t b;
        b.opcode = op;
        b.pixel = 8'($urandom_range(0, 255));
        // bias toward the extremes now and then
        if ($urandom_range(0, 9) == 0)
            b.pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return b;
    endfunction

    // Output side: random stalls, compare against oldest expectation
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected beat kind", 8'(out_data.result_kind),
                                    8'(out_data.result_kind));
                end
                else
                begin
                    out_beat_t want;
                    want = pending_results.pop_front();
                    if (out_data.result_kind !== want.result_kind)
                        report_mismatch("result_kind", 8'(out_data.result_kind),
                                        8'(want.result_kind));
                    if (out_data.mapped_pixel !== want.mapped_pixel)
                        report_mismatch("mapped_pixel", out_data.mapped_pixel,
                                        want.mapped_pixel);
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left <= gap_len();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        in_beat_t b;
        int       r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        errors = 0;
        cycles = 0;
        beats_sent = 0;
        results_seen = 0;
        builds_sent = 0;
        for (int k = 0; k < LEVELS; k++)
        begin
            src_hist[k] = '0;
            ref_hist[k] = '0;
            match_lut[k] = k[7:0];
        end
        src_total = '0;
        ref_total = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed[n])
        begin
            b.opcode = directed[n].opcode;
            b.pixel = directed[n].pixel;
            send_beat(b, directed[n].typed, directed[n].result);
        end

        // Random histograms, one build, then maps with noise
        wait_drained();
        @(posedge clk);
        send_beat('{OP_CLEAR, 8'd0}, 0, BUILT);
        for (int n = 0; n < RAND_COUNTS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 46)
                b = rand_beat(OP_CNT_SRC);
            else if (r < 92)
                b = rand_beat(OP_CNT_REF);
            else if (r < 96)
                b = rand_beat(OP_MAP);
            else
                b = rand_beat(3'($urandom_range(5, 7)));
            send_beat(b, 0, BUILT);
        end
        wait_drained();
        @(posedge clk);
        send_beat('{OP_BUILD, 8'($urandom_range(0, 255))}, 0, BUILT);
        for (int n = 0; n < RAND_MIXED; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                b = rand_beat(OP_MAP);
            else if (r < 88)
                b = rand_beat(OP_CNT_SRC);
            else if (r < 95)
                b = rand_beat(OP_CNT_REF);
            else
                b = rand_beat(3'($urandom_range(5, 7)));
            send_beat(b, 0, BUILT);
        end

        // Drain
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d beats, %0d results, %0d table builds in %0d cycles",
                 beats_sent, results_seen, builds_sent, cycles);
        $display("Empty, one-sided and tied histograms; unused opcodes; random stalls");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/hml_pkg.sv
rtl/hml_diff_unit.sv
rtl/histogram_matching_lut_top.sv
dv/tb.sv
